// ===== src/ipfd_pkg.sv =====
`default_nettype none
package ipfd_pkg;

	// accumulator and arithmetic widths
	localparam int ACC_W     = 32;
	localparam int E_W       = 18;
	localparam int OPA_W     = 20;
	localparam int GAIN_W    = 16;
	localparam int PROD_W    = OPA_W + GAIN_W + 1;
	localparam int ACC_SUM_W = ((ACC_W > PROD_W) ? ACC_W : PROD_W) + 1;

	localparam logic signed [ACC_SUM_W-1:0] ACC_MAX =
		{{(ACC_SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_SUM_W-1:0] ACC_MIN = ~ACC_MAX;

	// 100.0 in Q.8
	localparam int FULL_SCALE_Q = 25600;

	// x/99 for x < 2^15 as (x * DIV99_MUL) >> DIV99_SHIFT
	localparam logic [15:0] DIV99_MUL   = 16'd42367;
	localparam int          DIV99_SHIFT = 22;

	// register indexes
	localparam logic [1:0] REG_SETPOINT = 2'd0;
	localparam logic [1:0] REG_PROP     = 2'd1;
	localparam logic [1:0] REG_INTEG    = 2'd2;
	localparam logic [1:0] REG_DERIV    = 2'd3;

	localparam logic [14:0] SETPOINT_RST = 15'd10240;
	localparam logic [15:0] PROP_RST     = 16'd256;
	localparam logic [15:0] INTEG_RST    = 16'd26;
	localparam logic [15:0] DERIV_RST    = 16'd512;

	// clamp codes
	localparam logic [1:0] CLAMP_NONE = 2'd0;
	localparam logic [1:0] CLAMP_HI   = 2'd1;
	localparam logic [1:0] CLAMP_LO   = 2'd2;

	// microcode fields
	localparam logic [1:0] COND_ALWAYS   = 2'd0;
	localparam logic [1:0] COND_IN_VALID = 2'd1;
	localparam logic [1:0] COND_OUT_FREE = 2'd2;

	localparam logic [1:0] A_ERR = 2'd0;
	localparam logic [1:0] A_D2  = 2'd1;
	localparam logic [1:0] A_SUM = 2'd2;

	localparam logic [1:0] B_KI = 2'd0;
	localparam logic [1:0] B_KD = 2'd1;
	localparam logic [1:0] B_KP = 2'd2;

	localparam logic [2:0] STEP_TAKE  = 3'd0;
	localparam logic [2:0] STEP_MUL_I = 3'd1;
	localparam logic [2:0] STEP_MUL_D = 3'd2;
	localparam logic [2:0] STEP_ADD_D = 3'd3;
	localparam logic [2:0] STEP_MUL_P = 3'd4;
	localparam logic [2:0] STEP_ACC   = 3'd5;
	localparam logic [2:0] STEP_OUT   = 3'd6;

	typedef struct packed {
		logic [1:0] cond;
		logic       jump;
		logic [2:0] target;
		logic       in_take;
		logic       load_err;
		logic       mul_en;
		logic [1:0] a_sel;
		logic [1:0] b_sel;
		logic       sum_add;
		logic       acc_upd;
		logic       out_load;
	} ipfd_ctrl_t;

	// datapath enables, already qualified by the step condition
	typedef struct packed {
		logic       load_err;
		logic       mul_en;
		logic [1:0] a_sel;
		logic [1:0] b_sel;
		logic       sum_add;
		logic       acc_upd;
		logic       out_load;
	} ipfd_en_t;

	typedef struct packed {
		logic in_valid;
		logic out_free;
	} ipfd_stat_t;

	function automatic ipfd_ctrl_t ipfd_rom(input logic [2:0] pc);
		ipfd_ctrl_t cw;
		cw = '0;
		unique case (pc)
			STEP_TAKE: begin
				cw.cond     = COND_IN_VALID;
				cw.in_take  = 1'b1;
				cw.load_err = 1'b1;
			end
			STEP_MUL_I: begin
				cw.mul_en = 1'b1;
				cw.a_sel  = A_ERR;
				cw.b_sel  = B_KI;
			end
			STEP_MUL_D: begin
				cw.mul_en  = 1'b1;
				cw.a_sel   = A_D2;
				cw.b_sel   = B_KD;
				cw.sum_add = 1'b1;
			end
			STEP_ADD_D: begin
				cw.sum_add = 1'b1;
			end
			STEP_MUL_P: begin
				cw.mul_en = 1'b1;
				cw.a_sel  = A_SUM;
				cw.b_sel  = B_KP;
			end
			STEP_ACC: begin
				cw.acc_upd = 1'b1;
			end
			STEP_OUT: begin
				cw.cond     = COND_OUT_FREE;
				cw.out_load = 1'b1;
				cw.jump     = 1'b1;
				cw.target   = STEP_TAKE;
			end
			default: begin
				cw.jump   = 1'b1;
				cw.target = STEP_TAKE;
			end
		endcase
		return cw;
	endfunction

endpackage
`default_nettype wire

// ===== src/ipfd_in_if.sv =====
`default_nettype none
interface ipfd_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] temp_sample;

	modport source (output valid, output temp_sample, input ready);
	modport sink   (input valid, input temp_sample, output ready);
endinterface
`default_nettype wire

// ===== src/ipfd_out_if.sv =====
`default_nettype none
interface ipfd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] fan_duty;
	logic [1:0] clamp_code;

	modport source (output valid, output fan_duty, output clamp_code, input ready);
	modport sink   (input valid, input fan_duty, input clamp_code, output ready);
endinterface
`default_nettype wire

// ===== src/ipfd_seq.sv =====
`default_nettype none
module ipfd_seq (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ipfd_pkg::ipfd_stat_t st,
	output ipfd_pkg::ipfd_en_t        en,
	output logic                      in_ready
);

	logic [2:0]           pc_q;
	logic [2:0]           pc_d;
	ipfd_pkg::ipfd_ctrl_t cw;
	logic                 go;

	assign cw = ipfd_pkg::ipfd_rom(pc_q);

	always_comb begin
		unique case (cw.cond)
			ipfd_pkg::COND_ALWAYS:   go = 1'b1;
			ipfd_pkg::COND_IN_VALID: go = st.in_valid;
			ipfd_pkg::COND_OUT_FREE: go = st.out_free;
			default:                 go = 1'b0;
		endcase
	end

	always_comb begin
		if (!go) begin
			pc_d = pc_q;
		end else if (cw.jump) begin
			pc_d = cw.target;
		end else begin
			pc_d = pc_q + 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ipfd_pkg::STEP_TAKE;
		end else begin
			pc_q <= pc_d;
		end
	end

	assign in_ready    = cw.in_take;
	assign en.load_err = cw.load_err & go;
	assign en.mul_en   = cw.mul_en & go;
	assign en.a_sel    = cw.a_sel;
	assign en.b_sel    = cw.b_sel;
	assign en.sum_add  = cw.sum_add & go;
	assign en.acc_upd  = cw.acc_upd & go;
	assign en.out_load = cw.out_load & go;

`ifndef SYNTHESIS
	// step counter stays inside the program
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= ipfd_pkg::STEP_OUT)
		else $error("sequencer left the program");
`endif

endmodule
`default_nettype wire

// ===== src/ipfd_dp.sv =====
`default_nettype none
module ipfd_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_idx,
	input  wire logic [15:0]        cfg_data,
	input  wire ipfd_pkg::ipfd_en_t en,
	input  wire logic signed [15:0] temp_sample,
	input  wire logic               out_ready,
	output logic                    out_valid,
	output logic [7:0]              fan_duty,
	output logic [1:0]              clamp_code,
	output logic                    out_free
);

	localparam int AW = ipfd_pkg::ACC_W;
	localparam int SW = ipfd_pkg::ACC_SUM_W;
	localparam int PW = ipfd_pkg::PROD_W;
	localparam int EW = ipfd_pkg::E_W;
	localparam int OW = ipfd_pkg::OPA_W;
	localparam int GW = ipfd_pkg::GAIN_W;

	// configuration
	logic [14:0]   sp_q;
	logic [GW-1:0] kp_q;
	logic [GW-1:0] ki_q;
	logic [GW-1:0] kd_q;

	// controller state
	logic signed [EW-1:0] e1_q;
	logic signed [EW-1:0] e2_q;
	logic signed [AW-1:0] acc_q;

	// working registers
	logic signed [EW-1:0] err_q;
	logic signed [OW-1:0] d2_q;
	logic signed [OW-1:0] sum_q;
	logic signed [PW-1:0] prod_q;
	logic                 out_valid_q;
	logic [7:0]           duty_q;
	logic [1:0]           code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= ipfd_pkg::SETPOINT_RST;
			kp_q <= ipfd_pkg::PROP_RST;
			ki_q <= ipfd_pkg::INTEG_RST;
			kd_q <= ipfd_pkg::DERIV_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				ipfd_pkg::REG_SETPOINT: sp_q <= cfg_data[14:0];
				ipfd_pkg::REG_PROP:     kp_q <= cfg_data;
				ipfd_pkg::REG_INTEG:    ki_q <= cfg_data;
				ipfd_pkg::REG_DERIV:    kd_q <= cfg_data;
				default:                sp_q <= sp_q;
			endcase
		end
	end

	// error, first and second differences
	logic signed [EW-1:0] err_d;
	logic signed [EW:0]   d1;
	logic signed [EW:0]   d1_b;
	logic signed [EW:0]   tch;
	logic signed [OW-1:0] d2_d;

	always_comb begin
		err_d = {3'b000, sp_q} - {{(EW-16){temp_sample[15]}}, temp_sample};
		d1    = {err_d[EW-1], err_d} - {e1_q[EW-1], e1_q};
		d1_b  = d1 + (d1[EW] ? (EW+1)'(255) : (EW+1)'(0));
		tch   = d1_b >>> 8;
		d2_d  = {{(OW-EW){err_d[EW-1]}}, err_d}
		      - {{(OW-EW-1){e1_q[EW-1]}}, e1_q, 1'b0}
		      + {{(OW-EW){e2_q[EW-1]}}, e2_q};
	end

	// shared multiplier
	logic signed [OW-1:0] opa;
	logic [GW-1:0]        opb;
	logic signed [PW-1:0] prod_d;

	always_comb begin
		unique case (en.a_sel)
			ipfd_pkg::A_ERR: opa = {{(OW-EW){err_q[EW-1]}}, err_q};
			ipfd_pkg::A_D2:  opa = d2_q;
			ipfd_pkg::A_SUM: opa = sum_q;
			default:         opa = sum_q;
		endcase
		unique case (en.b_sel)
			ipfd_pkg::B_KI: opb = ki_q;
			ipfd_pkg::B_KD: opb = kd_q;
			ipfd_pkg::B_KP: opb = kp_q;
			default:        opb = kp_q;
		endcase
		prod_d = opa * $signed({1'b0, opb});
	end

	// whole degrees of a signed Q21.16 product, toward zero
	logic signed [PW-1:0] prod_b;
	logic signed [PW-1:0] t16;

	always_comb begin
		prod_b = prod_q + (prod_q[PW-1] ? PW'(65535) : PW'(0));
		t16    = prod_b >>> 16;
	end

	// saturating accumulate
	logic signed [SW-1:0] acc_sum;
	logic signed [AW-1:0] acc_d;

	always_comb begin
		acc_sum = {{(SW-AW){acc_q[AW-1]}}, acc_q} + {{(SW-PW){prod_q[PW-1]}}, prod_q};
		priority if (acc_sum > ipfd_pkg::ACC_MAX) begin
			acc_d = ipfd_pkg::ACC_MAX[AW-1:0];
		end else if (acc_sum < ipfd_pkg::ACC_MIN) begin
			acc_d = ipfd_pkg::ACC_MIN[AW-1:0];
		end else begin
			acc_d = acc_sum[AW-1:0];
		end
	end

	// duty mapping: whole*255/99 via reciprocal
	logic [6:0]  whole;
	logic [14:0] scaled;
	logic [30:0] qprod;
	logic [8:0]  quot;
	logic        over;
	logic [7:0]  duty_d;
	logic [1:0]  code_d;

	always_comb begin
		whole  = acc_q[14:8];
		scaled = {whole, 8'b0} - {8'b0, whole};
		qprod  = 31'(scaled) * 31'(ipfd_pkg::DIV99_MUL);
		quot   = qprod[30:ipfd_pkg::DIV99_SHIFT];
		over   = acc_q > AW'(ipfd_pkg::FULL_SCALE_Q);
		priority if (over) begin
			duty_d = 8'd255;
			code_d = ipfd_pkg::CLAMP_HI;
		end else if (acc_q[AW-1]) begin
			duty_d = 8'd0;
			code_d = ipfd_pkg::CLAMP_LO;
		end else begin
			duty_d = quot[8] ? 8'd255 : quot[7:0];
			code_d = ipfd_pkg::CLAMP_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e1_q        <= '0;
			e2_q        <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (en.acc_upd) begin
				acc_q <= acc_d;
				e2_q  <= e1_q;
				e1_q  <= err_q;
			end
			if (en.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.load_err) begin
			err_q <= err_d;
			d2_q  <= d2_d;
			sum_q <= {tch[EW], tch};
		end else if (en.sum_add) begin
			sum_q <= sum_q + t16[OW-1:0];
		end
		if (en.mul_en) begin
			prod_q <= prod_d;
		end
		if (en.out_load) begin
			duty_q <= duty_d;
			code_q <= code_d;
		end
	end

	assign out_free   = !out_valid_q || out_ready;
	assign out_valid  = out_valid_q;
	assign fan_duty   = duty_q;
	assign clamp_code = code_q;

`ifndef SYNTHESIS
	a_out_slot: assert property (@(posedge clk) disable iff (!arst_n)
		en.out_load |-> (!out_valid_q || out_ready))
		else $error("result loaded over a pending transaction");

	a_clamp_duty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((code_q == ipfd_pkg::CLAMP_HI && duty_q == 8'd255)
			|| (code_q == ipfd_pkg::CLAMP_LO && duty_q == 8'd0)
			|| code_q == ipfd_pkg::CLAMP_NONE))
		else $error("clamp code disagrees with duty");

	a_err_shift: assert property (@(posedge clk) disable iff (!arst_n)
		en.acc_upd |=> (e1_q == $past(err_q) && e2_q == $past(e1_q)))
		else $error("error history not shifted");
`endif

endmodule
`default_nettype wire

// ===== src/incremental_pid_fan_duty_top.sv =====
`default_nettype none
// Incremental PID fan duty: temperature sample in, PWM duty and clamp code out.
// The microcode program (7 steps through one shared 20x17 multiplier) works on
//   one sample at a time; a new sample is taken only after the last result has
//   been loaded into the output register.
// Reset (arst_n low, async): registers return to their defaults, error history
//   and accumulator clear, sequencer goes to its input step, no result pending.
module incremental_pid_fan_duty_top (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   cfg_we,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [15:0] cfg_data,
	ipfd_in_if.sink     in_ch,
	ipfd_out_if.source  out_ch
);

	// Sequencer walks the microcode ROM:
	//   take sample and form error terms, Ki*e, Kd*d2 (+ add Ki term),
	//   add Kd term, Kp*sum, saturating accumulate, then map to duty and
	//   hand over once the output register is free.
	ipfd_pkg::ipfd_en_t   en;
	ipfd_pkg::ipfd_stat_t st;
	logic                 out_free;
	logic                 in_ready;

	assign st.in_valid = in_ch.valid;
	assign st.out_free = out_free;
	assign in_ch.ready = in_ready;

	ipfd_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.st       (st),
		.en       (en),
		.in_ready (in_ready)
	);

	// Datapath: config registers, error history, shared multiplier,
	// accumulator and an output register that holds the pending transaction
	// so the next sample can be worked on while it waits.
	ipfd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.en          (en),
		.temp_sample (in_ch.temp_sample),
		.out_ready   (out_ch.ready),
		.out_valid   (out_ch.valid),
		.fan_duty    (out_ch.fan_duty),
		.clamp_code  (out_ch.clamp_code),
		.out_free    (out_free)
	);

endmodule
`default_nettype wire
